// ===== hw/rtl/stpd_pkg.sv =====
// shared widths, constants, register indexes and the stage struct of the sine tone generator
// also holds the elaboration-time builder for the quarter-wave sine table
`timescale 1ns / 1ps

package stpd_pkg;

    localparam int TABLE_ADDR_BITS_DEF = 10;
    localparam int PHASE_BITS_DEF      = 32;

    localparam int STEP_W   = 32;
    localparam int PERIOD_W = 16;
    localparam int DUTY_W   = 16;
    localparam int MAG_W    = 11;
    localparam int SAMPLE_W = 12;
    localparam int PROD_W   = SAMPLE_W + PERIOD_W;

    localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd839;
    localparam logic [SAMPLE_W-1:0] MID_CODE   = 12'd2048;
    localparam int                  FULL_CODE  = 4095;
    localparam longint unsigned     TONE_AMP   = 64'd1500;
    localparam longint unsigned     HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [0:0] {
        CFG_PHASE_STEP = 1'b0,
        CFG_PWM_PERIOD = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic             valid;
        logic             neg;
        logic [MAG_W-1:0] mag;
    } t_tone;

    // truncated 1500*sin(m/2^qbits * pi/2), Q30 Taylor series to the 15th power
    function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned m,
                                                      input int unsigned qbits);
        longint unsigned theta;
        longint unsigned th2;
        longint unsigned term;
        longint unsigned prod;
        longint unsigned pos;
        longint unsigned neg;
        longint unsigned s;
        int unsigned     i;
        if (m == 0) begin
            return '0;
        end
        if (m >= (32'd1 << qbits)) begin
            return MAG_W'(TONE_AMP);
        end
        theta = (HALF_PI_Q30 * longint'(m)) >> qbits;
        th2   = (theta * theta) >> 30;
        term  = theta;
        pos   = theta;
        neg   = 0;
        for (i = 1; i <= 7; i++) begin
            prod = (term * th2) >> 30;
            unique case (i)
                1: begin
                    term = prod / 6;
                end
                2: begin
                    term = prod / 20;
                end
                3: begin
                    term = prod / 42;
                end
                4: begin
                    term = prod / 72;
                end
                5: begin
                    term = prod / 110;
                end
                6: begin
                    term = prod / 156;
                end
                default: begin
                    term = prod / 210;
                end
            endcase
            if (i[0]) begin
                neg = neg + term;
            end else begin
                pos = pos + term;
            end
        end
        s = (pos > neg) ? pos - neg : 64'd0;
        if (s > (64'd1 << 30)) begin
            s = 64'd1 << 30;
        end
        return MAG_W'((TONE_AMP * s) >> 30);
    endfunction

endpackage

// ===== hw/rtl/stpd_phase.sv =====
// phase accumulator and quarter-wave address folding
// depends on stpd_pkg
`timescale 1ns / 1ps

module stpd_phase #(
    parameter int TABLE_ADDR_BITS = stpd_pkg::TABLE_ADDR_BITS_DEF,
    parameter int PHASE_BITS      = stpd_pkg::PHASE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic                       i_restart,
    input  logic [PHASE_BITS-1:0]      i_step,
    output logic [TABLE_ADDR_BITS-2:0] o_index,
    output logic                       o_neg
);

    localparam int IDX_W = TABLE_ADDR_BITS - 1;
    localparam int QLEN  = 1 << (TABLE_ADDR_BITS - 2);

    logic [PHASE_BITS-1:0]      r_phase;
    logic [PHASE_BITS-1:0]      n_phase;
    logic [PHASE_BITS-1:0]      w_used;
    logic [TABLE_ADDR_BITS-1:0] w_top;
    logic [IDX_W-1:0]           w_r;

    assign w_used  = i_restart ? '0 : r_phase;
    assign w_top   = w_used[PHASE_BITS-1 -: TABLE_ADDR_BITS];
    assign w_r     = {1'b0, w_top[TABLE_ADDR_BITS-3:0]};
    assign o_index = w_top[TABLE_ADDR_BITS-2] ? (IDX_W'(QLEN) - w_r) : w_r;
    assign o_neg   = w_top[TABLE_ADDR_BITS-1];
    assign n_phase = w_used + i_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
        end
    end

    a_restart_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_restart) |=> r_phase == $past(i_step))
        else $error("phase after restart is not the step");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !i_restart) |=> r_phase == $past(r_phase + i_step))
        else $error("phase did not advance by the step");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_accept |=> $stable(r_phase))
        else $error("phase moved without an item");

endmodule

// ===== hw/rtl/stpd_sine_rom.sv =====
// quarter-wave sine magnitude table with registered read, first pipeline stage
// depends on stpd_pkg
`timescale 1ns / 1ps

module stpd_sine_rom #(
    parameter int TABLE_ADDR_BITS = stpd_pkg::TABLE_ADDR_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [TABLE_ADDR_BITS-2:0] i_index,
    input  logic                       i_neg,
    input  logic                       i_ready,
    output logic                       o_ready,
    output stpd_pkg::t_tone            o_stage
);

    localparam int QLEN = 1 << (TABLE_ADDR_BITS - 2);

    logic [stpd_pkg::MAG_W-1:0] w_rom [0:QLEN];
    logic                       r_valid;
    logic                       r_neg;
    logic [stpd_pkg::MAG_W-1:0] r_mag;

    for (genvar g = 0; g <= QLEN; g++) begin : g_rom
        assign w_rom[g] = stpd_pkg::quarter_sine(g, TABLE_ADDR_BITS - 2);
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_mag <= w_rom[i_index];
            r_neg <= i_neg;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.neg   = r_neg;
    assign o_stage.mag   = r_mag;

endmodule

// ===== hw/rtl/stpd_scale.sv =====
// sample forming, duty multiply and divide by full scale over three stages
// depends on stpd_pkg
`timescale 1ns / 1ps

module stpd_scale (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  stpd_pkg::t_tone               i_stage,
    input  logic [stpd_pkg::PERIOD_W-1:0] i_period,
    output logic                          o_ready,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [stpd_pkg::DUTY_W-1:0]   o_duty
);

    localparam int PW = stpd_pkg::PROD_W;
    localparam int DW = stpd_pkg::DUTY_W;

    logic                           r_v2;
    logic                           r_v3;
    logic                           r_v4;
    logic                           w_rdy3;
    logic                           w_rdy4;
    logic [stpd_pkg::SAMPLE_W-1:0]  w_sample;
    logic [PW-1:0]                  r_prod;
    logic [PW-1:0]                  r_x;
    logic [DW-1:0]                  r_q0;
    logic [PW:0]                    w_sum;
    logic [PW+1:0]                  w_rem;
    logic [DW-1:0]                  r_duty;

    assign w_rdy4  = !r_v4 || i_ready;
    assign w_rdy3  = !r_v3 || w_rdy4;
    assign o_ready = !r_v2 || w_rdy3;

    // 11-bit magnitude keeps the sample inside 0..4095
    assign w_sample = i_stage.neg ? (stpd_pkg::MID_CODE - stpd_pkg::SAMPLE_W'(i_stage.mag))
                                  : (stpd_pkg::MID_CODE + stpd_pkg::SAMPLE_W'(i_stage.mag));

    // quotient estimate by 1/4095 series, low by at most one
    assign w_sum = {1'b0, r_prod} + (PW+1)'(r_prod >> 12) + (PW+1)'(r_prod >> 24);
    assign w_rem = {2'b00, r_x} + (PW+2)'(r_q0) - (PW+2)'({r_q0, 12'd0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (o_ready) begin
                r_v2 <= i_stage.valid;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
            if (w_rdy4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_stage.valid && o_ready) begin
            r_prod <= PW'(w_sample) * PW'(i_period);
        end
        if (r_v2 && w_rdy3) begin
            r_x  <= r_prod;
            r_q0 <= DW'(w_sum >> 12);
        end
        if (r_v3 && w_rdy4) begin
            r_duty <= (w_rem >= (PW+2)'(stpd_pkg::FULL_CODE)) ? r_q0 + 1'b1 : r_q0;
        end
    end

    assign o_valid = r_v4;
    assign o_duty  = r_duty;

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> w_rem < (PW+2)'(2 * stpd_pkg::FULL_CODE))
        else $error("quotient estimate off by more than one");

    a_prod_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !w_rdy3) |=> (r_v2 && $stable(r_prod)))
        else $error("product stage lost an item under stall");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && r_v3 && r_v4 && !i_ready) |-> !o_ready)
        else $error("full pipe took an item while stalled");

endmodule

// ===== hw/rtl/sine_tone_to_pwm_duty_top.sv =====
// Sine tone generator: one PWM compare value per item, one item per clock when not stalled.
// A result reaches the output register through these stages: the phase picks the table address
// and the registered sine table read happens at the edge that accepts its item, then sample and
// multiply by the period, then the quotient estimate by 1/4095, then its correction into the
// output register. Backpressure stalls the stages in turn, so empty stages still take items.
// The table holds a quarter wave of 2^(TABLE_ADDR_BITS-2)+1 magnitudes. The user must write
// phase_step (index 0) and pwm_period (index 1) only while no item is in flight; the block itself
// does not enforce this. restart clears the phase before that item's sample.
// depends on stpd_pkg, stpd_phase, stpd_sine_rom, stpd_scale
`timescale 1ns / 1ps

module sine_tone_to_pwm_duty_top #(
    parameter int TABLE_ADDR_BITS = stpd_pkg::TABLE_ADDR_BITS_DEF,
    parameter int PHASE_BITS      = stpd_pkg::PHASE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [0:0]                    i_cfg_idx,
    input  logic [stpd_pkg::STEP_W-1:0]   i_cfg_wdata,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_restart,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [stpd_pkg::DUTY_W-1:0]   o_duty
);

    logic [stpd_pkg::STEP_W-1:0]   r_step;
    logic [stpd_pkg::PERIOD_W-1:0] r_period;
    logic [TABLE_ADDR_BITS-2:0]    w_index;
    logic                          w_neg;
    logic                          w_rdy2;
    stpd_pkg::t_tone               w_tone;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= '0;
            r_period <= stpd_pkg::PERIOD_RST;
        end else if (i_cfg_we) begin
            unique case (stpd_pkg::t_cfg_idx'(i_cfg_idx))
                stpd_pkg::CFG_PHASE_STEP: begin
                    r_step <= i_cfg_wdata;
                end
                stpd_pkg::CFG_PWM_PERIOD: begin
                    r_period <= i_cfg_wdata[stpd_pkg::PERIOD_W-1:0];
                end
            endcase
        end
    end

    stpd_phase #(
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
        .PHASE_BITS      (PHASE_BITS)
    ) u_phase (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (i_valid && o_ready),
        .i_restart (i_restart),
        .i_step    (r_step[PHASE_BITS-1:0]),
        .o_index   (w_index),
        .o_neg     (w_neg)
    );

    stpd_sine_rom #(
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
    ) u_rom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_index (w_index),
        .i_neg   (w_neg),
        .i_ready (w_rdy2),
        .o_ready (o_ready),
        .o_stage (w_tone)
    );

    stpd_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_stage  (w_tone),
        .i_period (r_period),
        .o_ready  (w_rdy2),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_duty   (o_duty)
    );

endmodule
